### sv/i2c_register_access_sequencer_core_assert.svh
// Assertion macros for the I2C register access sequencer checker.
// Depends on nothing; included by the checker file only.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_CORE_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CRAS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CRAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/i2cras_pkg.sv
// Shared types and codes for the I2C register access sequencer.
// No dependencies; imported by every module of the block.
package i2cras_pkg;

   localparam int MAX_RSP = 3;

   // request function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_WDATA = 2'd1;
   localparam logic [1:0] FUNC_DONE  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CMD    = 2'd0;
   localparam logic [1:0] KIND_RDATA  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // bus engine commands
   localparam logic [2:0] BUS_START = 3'd0;
   localparam logic [2:0] BUS_SEND  = 3'd1;
   localparam logic [2:0] BUS_RXACK = 3'd2;
   localparam logic [2:0] BUS_RXNAK = 3'd3;
   localparam logic [2:0] BUS_STOP  = 3'd4;

   // error codes
   localparam logic [3:0] ERR_NONE    = 4'd0;
   localparam logic [3:0] ERR_START   = 4'd1;
   localparam logic [3:0] ERR_WADDR   = 4'd2;
   localparam logic [3:0] ERR_REG     = 4'd3;
   localparam logic [3:0] ERR_WDATA   = 4'd4;
   localparam logic [3:0] ERR_RESTART = 4'd5;
   localparam logic [3:0] ERR_RADDR   = 4'd6;
   localparam logic [3:0] ERR_DACK    = 4'd7;
   localparam logic [3:0] ERR_DNACK   = 4'd8;

   // bus status codes after masking
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] ST_START_SENT   = 8'h08;
   localparam logic [7:0] ST_RESTART_SENT = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
   localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
   localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NAK  = 8'h58;

   typedef struct packed {
      logic [1:0] func;
      logic       is_read;
      logic [6:0] device_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] wdata;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] bus_cmd;
      logic [7:0] tx_byte;
      logic [7:0] rdata;
      logic [3:0] error_code;
      logic       last;
   } rsp_type;

   // results of one request, slot 0 first
   typedef struct packed {
      logic [1:0]                count;
      rsp_type [MAX_RSP-1:0]     items;
   } rsp_batch_type;

endpackage

### sv/i2cras_engine.sv
// Transaction sequencer: phase state and the per-request step logic.
// Depends on i2cras_pkg; produces up to three results per request.
module i2cras_engine import i2cras_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  req_type       item,
   output rsp_batch_type batch
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_W_START,
      PH_W_SLA,
      PH_W_REG,
      PH_HOST_WAIT,
      PH_W_DATA,
      PH_R_RESTART,
      PH_R_SLA,
      PH_R_DATA
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       read_mode_ff, read_mode_in;
   logic [6:0] target_addr_ff, target_addr_in;
   logic [7:0] register_byte_ff, register_byte_in;
   logic [7:0] bytes_left_ff, bytes_left_in;

   logic       rx_hit, cmd_hit, fin_hit;
   logic [2:0] cmd_val;
   logic [7:0] tx_val;
   logic [3:0] fin_err;
   logic [7:0] left_dec;
   logic [7:0] status;
   rsp_type    rd_item, cmd_item, stop_item, fin_item;

   assign status   = item.bus_status & STATUS_MASK;
   assign left_dec = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in         = phase_ff;
      read_mode_in     = read_mode_ff;
      target_addr_in   = target_addr_ff;
      register_byte_in = register_byte_ff;
      bytes_left_in    = bytes_left_ff;
      rx_hit  = 1'b0;
      cmd_hit = 1'b0;
      fin_hit = 1'b0;
      cmd_val = BUS_START;
      tx_val  = 8'd0;
      fin_err = ERR_NONE;
      if (item_valid) begin
         unique case (item.func)
            FUNC_START: begin
               if (phase_ff == PH_IDLE) begin
                  read_mode_in     = item.is_read;
                  target_addr_in   = item.device_addr;
                  register_byte_in = item.reg_addr;
                  bytes_left_in    = item.byte_count;
                  cmd_hit          = 1'b1;
                  cmd_val          = BUS_START;
                  phase_in         = PH_W_START;
               end
            end
            FUNC_WDATA: begin
               if (phase_ff == PH_HOST_WAIT) begin
                  cmd_hit  = 1'b1;
                  cmd_val  = BUS_SEND;
                  tx_val   = item.wdata;
                  phase_in = PH_W_DATA;
               end
            end
            FUNC_DONE: begin
               unique case (phase_ff)
                  PH_W_START: begin
                     if (status != ST_START_SENT) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_START;
                     end else begin
                        cmd_hit  = 1'b1;
                        cmd_val  = BUS_SEND;
                        tx_val   = {target_addr_ff, 1'b0};
                        phase_in = PH_W_SLA;
                     end
                  end
                  PH_W_SLA: begin
                     if (status != ST_SLA_W_ACK) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_WADDR;
                     end else begin
                        cmd_hit  = 1'b1;
                        cmd_val  = BUS_SEND;
                        tx_val   = register_byte_ff;
                        phase_in = PH_W_REG;
                     end
                  end
                  PH_W_REG: begin
                     if (status != ST_DATA_TX_ACK) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_REG;
                     end else if (read_mode_ff) begin
                        cmd_hit  = 1'b1;
                        cmd_val  = BUS_START;
                        phase_in = PH_R_RESTART;
                     end else if (bytes_left_ff == 8'd0) begin
                        fin_hit = 1'b1;
                     end else begin
                        phase_in = PH_HOST_WAIT;
                     end
                  end
                  PH_W_DATA: begin
                     if (status != ST_DATA_TX_ACK) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_WDATA;
                     end else begin
                        bytes_left_in = left_dec;
                        if (left_dec == 8'd0) begin
                           fin_hit = 1'b1;
                        end else begin
                           phase_in = PH_HOST_WAIT;
                        end
                     end
                  end
                  PH_R_RESTART: begin
                     if (status != ST_RESTART_SENT) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_RESTART;
                     end else begin
                        cmd_hit  = 1'b1;
                        cmd_val  = BUS_SEND;
                        tx_val   = {target_addr_ff, 1'b1};
                        phase_in = PH_R_SLA;
                     end
                  end
                  PH_R_SLA: begin
                     if (status != ST_SLA_R_ACK) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_RADDR;
                     end else if (bytes_left_ff == 8'd0) begin
                        fin_hit = 1'b1;
                     end else begin
                        cmd_hit  = 1'b1;
                        cmd_val  = (bytes_left_ff == 8'd1) ? BUS_RXNAK : BUS_RXACK;
                        phase_in = PH_R_DATA;
                     end
                  end
                  PH_R_DATA: begin
                     if (bytes_left_ff > 8'd1 && status != ST_DATA_RX_ACK) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_DACK;
                     end else if (bytes_left_ff <= 8'd1 && status != ST_DATA_RX_NAK) begin
                        fin_hit = 1'b1;
                        fin_err = ERR_DNACK;
                     end else begin
                        rx_hit        = 1'b1;
                        bytes_left_in = left_dec;
                        if (left_dec == 8'd0) begin
                           fin_hit = 1'b1;
                        end else begin
                           cmd_hit = 1'b1;
                           cmd_val = (left_dec == 8'd1) ? BUS_RXNAK : BUS_RXACK;
                        end
                     end
                  end
                  default: ;
               endcase
               if (fin_hit) begin
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   // pack the results in order: read data, command, then stop and finish
   always_comb begin
      rd_item            = '0;
      rd_item.kind       = KIND_RDATA;
      rd_item.rdata      = item.rx_byte;
      cmd_item           = '0;
      cmd_item.kind      = KIND_CMD;
      cmd_item.bus_cmd   = cmd_val;
      cmd_item.tx_byte   = tx_val;
      stop_item          = '0;
      stop_item.kind     = KIND_CMD;
      stop_item.bus_cmd  = BUS_STOP;
      fin_item           = '0;
      fin_item.kind      = KIND_FINISH;
      fin_item.error_code = fin_err;

      batch.count = 2'({1'b0, rx_hit} + {1'b0, cmd_hit} + {fin_hit, 1'b0});
      batch.items[0] = rx_hit ? rd_item : (cmd_hit ? cmd_item : stop_item);
      batch.items[1] = rx_hit ? (cmd_hit ? cmd_item : stop_item) : fin_item;
      batch.items[2] = fin_item;
      for (int i = 0; i < MAX_RSP; i++) begin
         batch.items[i].last = (batch.count == 2'(i + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         read_mode_ff     <= 1'b0;
         target_addr_ff   <= 7'd0;
         register_byte_ff <= 8'd0;
         bytes_left_ff    <= 8'd0;
      end else begin
         phase_ff         <= phase_in;
         read_mode_ff     <= read_mode_in;
         target_addr_ff   <= target_addr_in;
         register_byte_ff <= register_byte_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

endmodule

### sv/i2cras_rsp_fifo.sv
// Result queue: takes up to three results per cycle, hands out one.
// Depends on i2cras_pkg for the result and batch types.
module i2cras_rsp_fifo import i2cras_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rsp_batch_type               push,
   input  logic                        pop,
   output logic                        head_valid,
   output rsp_type                     head,
   output logic [$clog2(DEPTH+1)-1:0]  fill
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(DEPTH);

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_idx [MAX_RSP];

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [1:0] step);
      logic [PTR_W:0] sum;
      sum = {1'b0, ptr} + (PTR_W + 1)'(step);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[PTR_W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < MAX_RSP; i++) begin
         wr_idx[i] = wrap_add(wr_ptr_ff, 2'(i));
      end
      wr_ptr_in = wrap_add(wr_ptr_ff, push.count);
      rd_ptr_in = pop ? wrap_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign fill       = count_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RSP; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_idx[i]] <= push.items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/i2c_register_access_sequencer_core.sv
// I2C register access sequencer. A request enters an input register; the next
// cycle the sequencer steps its phase and writes zero to three results
// (bus commands, read data, the finished item) into a result queue of
// RSP_DEPTH entries, which hands out one transaction per cycle on rsp_ while
// rsp_stall is low. A request can be taken every cycle while req_stall is
// low; results pass through the input register and the queue. req_stall rises
// when the queue could not take three results for the request in the input
// register plus three for one more request behind it, so over a long run
// requests go in only as fast as their results drain, one per unstalled cycle.
// Depends on i2cras_pkg, i2cras_engine and i2cras_rsp_fifo.
module i2c_register_access_sequencer_core import i2cras_pkg::*; #(
   parameter int RSP_DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int LIM_W = CNT_W + 1;
   localparam logic [LIM_W-1:0] FILL_LIMIT = LIM_W'(RSP_DEPTH - MAX_RSP);
   localparam logic [LIM_W-1:0] BURST     = LIM_W'(MAX_RSP);

   logic             s1_valid_ff;
   req_type          s1_data_ff;
   logic             req_accept;
   rsp_batch_type    batch;
   logic [CNT_W-1:0] fill;
   logic [LIM_W-1:0] fill_ahead;

   assign fill_ahead = {1'b0, fill} + (s1_valid_ff ? BURST : '0);
   assign req_stall  = (fill_ahead > FILL_LIMIT);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
   end

   i2cras_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_data_ff),
      .batch      (batch)
   );

   i2cras_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (batch),
      .pop        (rsp_valid && !rsp_stall),
      .head_valid (rsp_valid),
      .head       (rsp_data),
      .fill       (fill)
   );

endmodule

### sv/i2cras_checker.sv
// Port-level checks of the I2C register access sequencer, bound to the top.
// Depends on i2cras_pkg and i2c_register_access_sequencer_core_assert.svh.
`include "i2c_register_access_sequencer_core_assert.svh"

module i2cras_checker import i2cras_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_take;
   logic prev_stop_ff;

   assign rsp_take = rsp_valid && !rsp_stall;

   // remember whether the last delivered transaction was a stop command
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_stop_ff <= 1'b0;
      end else if (rsp_take) begin
         prev_stop_ff <= (rsp_data.kind == KIND_CMD) && (rsp_data.bus_cmd == BUS_STOP);
      end
   end

   `I2CRAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `I2CRAS_ASSERT_IMPLY(a_finish_last, clock, reset, rsp_valid && rsp_data.kind == KIND_FINISH, rsp_data.last, "finished item without last")
   `I2CRAS_ASSERT_IMPLY(a_finish_after_stop, clock, reset, rsp_take && rsp_data.kind == KIND_FINISH, prev_stop_ff, "finished item not preceded by stop")
   `I2CRAS_ASSERT_IMPLY(a_error_on_finish, clock, reset, rsp_valid && rsp_data.error_code != ERR_NONE, rsp_data.kind == KIND_FINISH, "error code outside finished item")

endmodule

bind i2c_register_access_sequencer_core i2cras_checker u_checker (.*);
